// ----- rtl/core/stma_pkg.sv -----
// stma_pkg: shared types and constants for the sparse triplet matrix adder.
// Used by stma_list_mem and sparse_triplet_matrix_add; depends on nothing.
`timescale 1ns / 1ps

package stma_pkg;

    localparam int unsigned ROW_W     = 16;
    localparam int unsigned COL_W     = 16;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned DIM_W     = 16;
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned RES_CNT_W = 6;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [OPCODE_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MERGE       = 2'd2;

    localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] REG_COLS_FIRST  = 2'd1;
    localparam logic [1:0] REG_ROWS_SECOND = 2'd2;
    localparam logic [1:0] REG_COLS_SECOND = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

// ----- rtl/core/stma_list_mem.sv -----
// stma_list_mem: one triplet list, single write port and one registered read port.
// Depends on stma_pkg for the entry type.
`timescale 1ns / 1ps

module stma_list_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  stma_pkg::entry_t      wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output stma_pkg::entry_t      rd_data
);

    stma_pkg::entry_t mem [DEPTH];
    stma_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sparse_triplet_matrix_add.sv -----
// sparse_triplet_matrix_add: top level, APB register file, list fill and merge sequencer.
// Depends on stma_pkg and stma_list_mem.
`timescale 1ns / 1ps

// A load command (start with opcode 0 or 1) keeps busy low, so loads can issue every
// cycle. A merge command raises busy and emits one entry per step: a single comparator
// and adder walk both lists, fed by the registered read port of each list memory, which
// is re-addressed every cycle with the next head index. A merge that finds mismatched
// dimensions or two empty lists keeps busy low and emits only the end marker. Each
// result beat appears on the result ports, marked by result_valid, in the cycle after
// the step that produced it and for one cycle only; the receiver cannot stall it. The
// user must write configuration over APB while no merge runs; the block does not check.

module sparse_triplet_matrix_add #(
    parameter int unsigned LIST_ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [stma_pkg::OPCODE_W-1:0]          opcode,
    input  logic [stma_pkg::ROW_W-1:0]             row_index,
    input  logic [stma_pkg::COL_W-1:0]             col_index,
    input  logic signed [stma_pkg::VAL_W-1:0]      entry_value,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [stma_pkg::PADDR_W-1:0]           paddr,
    input  logic [stma_pkg::PDATA_W-1:0]           pwdata,
    output logic [stma_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready,
    output logic                                   result_valid,
    output logic [stma_pkg::ROW_W-1:0]             out_row,
    output logic [stma_pkg::COL_W-1:0]             out_col,
    output logic signed [stma_pkg::VAL_W-1:0]      out_value,
    output logic                                   entry_present,
    output logic                                   last_entry
);

    localparam int unsigned IDX_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(LIST_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_ENTRIES);
    localparam logic [stma_pkg::RES_CNT_W-1:0] RES_LIMIT =
        stma_pkg::RES_CNT_W'(stma_pkg::MAX_RESULTS);

    // configuration registers
    logic [stma_pkg::DIM_W-1:0] rows_first_reg, cols_first_reg;
    logic [stma_pkg::DIM_W-1:0] rows_second_reg, cols_second_reg;
    logic                       cfg_wr;
    logic [stma_pkg::DIM_W-1:0] cfg_rd;

    // sequencer state
    stma_pkg::state_t                state_reg, state_next;
    logic [CNT_W-1:0]                first_count_reg, first_count_next;
    logic [CNT_W-1:0]                second_count_reg, second_count_next;
    logic [CNT_W-1:0]                a_reg, a_next;
    logic [CNT_W-1:0]                b_reg, b_next;
    logic [stma_pkg::RES_CNT_W-1:0]  k_reg, k_next;

    // result beat
    logic                            result_valid_reg, result_valid_next;
    stma_pkg::entry_t                out_entry_reg, out_entry_next;
    logic                            entry_present_reg, entry_present_next;
    logic                            last_entry_reg, last_entry_next;

    // list memories
    logic                            wr_first, wr_second;
    stma_pkg::entry_t                load_entry;
    stma_pkg::entry_t                head_first, head_second;
    logic [IDX_W-1:0]                rd_addr_first, rd_addr_second;

    // step datapath
    logic                            a_live, b_live;
    logic                            take_first, take_second;
    logic [31:0]                     pos_first, pos_second;
    logic signed [stma_pkg::VAL_W-1:0] sum_value;
    logic                            accept;
    logic                            dims_differ;
    logic                            merge_done;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            stma_pkg::REG_ROWS_FIRST:  cfg_rd = rows_first_reg;
            stma_pkg::REG_COLS_FIRST:  cfg_rd = cols_first_reg;
            stma_pkg::REG_ROWS_SECOND: cfg_rd = rows_second_reg;
            stma_pkg::REG_COLS_SECOND: cfg_rd = cols_second_reg;
            default:                   cfg_rd = '0;
        endcase
    end

    assign prdata = {{(stma_pkg::PDATA_W - stma_pkg::DIM_W){1'b0}}, cfg_rd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= '0;
            cols_first_reg  <= '0;
            rows_second_reg <= '0;
            cols_second_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                stma_pkg::REG_ROWS_FIRST:  rows_first_reg  <= pwdata[stma_pkg::DIM_W-1:0];
                stma_pkg::REG_COLS_FIRST:  cols_first_reg  <= pwdata[stma_pkg::DIM_W-1:0];
                stma_pkg::REG_ROWS_SECOND: rows_second_reg <= pwdata[stma_pkg::DIM_W-1:0];
                stma_pkg::REG_COLS_SECOND: cols_second_reg <= pwdata[stma_pkg::DIM_W-1:0];
                default:                   rows_first_reg  <= rows_first_reg;
            endcase
        end
    end

    assign busy   = (state_reg == stma_pkg::ST_MERGE);
    assign accept = start & ~busy;

    assign load_entry.row   = row_index;
    assign load_entry.col   = col_index;
    assign load_entry.value = entry_value;

    assign wr_first  = accept && (opcode == stma_pkg::OP_LOAD_FIRST)
                       && (first_count_reg < CNT_FULL);
    assign wr_second = accept && (opcode == stma_pkg::OP_LOAD_SECOND)
                       && (second_count_reg < CNT_FULL);

    assign dims_differ = (rows_first_reg != rows_second_reg)
                         || (cols_first_reg != cols_second_reg);

    // one compare and one add per step
    assign a_live     = (a_reg < first_count_reg);
    assign b_live     = (b_reg < second_count_reg);
    assign pos_first  = {head_first.row, head_first.col};
    assign pos_second = {head_second.row, head_second.col};
    assign sum_value  = head_first.value + head_second.value;
    assign take_first  = a_live && (!b_live || (pos_first <= pos_second));
    assign take_second = b_live && (!a_live || (pos_second <= pos_first));

    always_comb
    begin
        state_next         = state_reg;
        first_count_next   = first_count_reg;
        second_count_next  = second_count_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        k_next             = k_reg;
        result_valid_next  = 1'b0;
        out_entry_next     = out_entry_reg;
        entry_present_next = entry_present_reg;
        last_entry_next    = last_entry_reg;
        merge_done         = 1'b0;

        case (state_reg)
            stma_pkg::ST_IDLE:
            begin
                if (wr_first)
                begin
                    first_count_next = first_count_reg + CNT_W'(1);
                end
                if (wr_second)
                begin
                    second_count_next = second_count_reg + CNT_W'(1);
                end
                if (accept && (opcode == stma_pkg::OP_MERGE))
                begin
                    if (dims_differ || ((first_count_reg == '0) && (second_count_reg == '0)))
                    begin
                        result_valid_next  = 1'b1;
                        out_entry_next     = '0;
                        entry_present_next = 1'b0;
                        last_entry_next    = 1'b1;
                        first_count_next   = '0;
                        second_count_next  = '0;
                    end
                    else
                    begin
                        state_next = stma_pkg::ST_MERGE;
                        a_next     = '0;
                        b_next     = '0;
                        k_next     = '0;
                    end
                end
            end
            stma_pkg::ST_MERGE:
            begin
                result_valid_next  = 1'b1;
                entry_present_next = 1'b1;
                if (take_first && take_second)
                begin
                    out_entry_next.row   = head_first.row;
                    out_entry_next.col   = head_first.col;
                    out_entry_next.value = sum_value;
                end
                else if (take_first)
                begin
                    out_entry_next = head_first;
                end
                else
                begin
                    out_entry_next = head_second;
                end
                if (take_first)
                begin
                    a_next = a_reg + CNT_W'(1);
                end
                if (take_second)
                begin
                    b_next = b_reg + CNT_W'(1);
                end
                k_next = k_reg + stma_pkg::RES_CNT_W'(1);
                merge_done = (k_next == RES_LIMIT)
                             || ((a_next >= first_count_reg) && (b_next >= second_count_reg));
                last_entry_next = merge_done;
                if (merge_done)
                begin
                    state_next        = stma_pkg::ST_IDLE;
                    first_count_next  = '0;
                    second_count_next = '0;
                end
            end
            default:
            begin
                state_next = stma_pkg::ST_IDLE;
            end
        endcase
    end

    // address the next heads so their data lands for the following step
    assign rd_addr_first  = busy ? a_next[IDX_W-1:0] : '0;
    assign rd_addr_second = busy ? b_next[IDX_W-1:0] : '0;

    stma_list_mem #(
        .DEPTH  (LIST_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_first_list (
        .clk     (clk),
        .wr_en   (wr_first),
        .wr_addr (first_count_reg[IDX_W-1:0]),
        .wr_data (load_entry),
        .rd_addr (rd_addr_first),
        .rd_data (head_first)
    );

    stma_list_mem #(
        .DEPTH  (LIST_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_second_list (
        .clk     (clk),
        .wr_en   (wr_second),
        .wr_addr (second_count_reg[IDX_W-1:0]),
        .wr_data (load_entry),
        .rd_addr (rd_addr_second),
        .rd_data (head_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stma_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg     <= out_entry_next;
        entry_present_reg <= entry_present_next;
        last_entry_reg    <= last_entry_next;
    end

    assign result_valid  = result_valid_reg;
    assign out_row       = out_entry_reg.row;
    assign out_col       = out_entry_reg.col;
    assign out_value     = out_entry_reg.value;
    assign entry_present = entry_present_reg;
    assign last_entry    = last_entry_reg;

`ifndef SYNTHESIS
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !entry_present) |-> last_entry)
        else $error("end marker without last_entry");

    a_merge_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last_entry))
        else $error("merge left without a last beat");

    a_last_clears_lists: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_entry) |-> ((first_count_reg == '0) && (second_count_reg == '0)))
        else $error("lists not cleared after merge");

    a_merge_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (a_live || b_live))
        else $error("merge step with both lists exhausted");
`endif

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for sparse_triplet_matrix_add (load, merge, APB sizes).
// Drives a directed table and random triplet lists and checks each result beat in order.
// Depends on stma_pkg and the sparse_triplet_matrix_add RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int LIST_DEPTH  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;

    localparam logic [stma_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [stma_pkg::ROW_W-1:0] row;
        logic [stma_pkg::COL_W-1:0] col;
        logic [stma_pkg::VAL_W-1:0] value;
        logic                       present;
        logic                       last;
    } sum_t;

    typedef struct packed {
        logic                          is_cfg;
        logic [1:0]                    cfg_reg;
        logic [stma_pkg::OPCODE_W-1:0] op;
        logic [stma_pkg::ROW_W-1:0]    row;
        logic [stma_pkg::COL_W-1:0]    col;
        logic [stma_pkg::VAL_W-1:0]    val;
        logic [7:0]                    reps;
        logic                          typed;
        sum_t                          want;
    } step_t;

    localparam sum_t UNTYPED   = '0;
    localparam sum_t END_MARK  = '{16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1};
    localparam sum_t WRAP_SUM  = '{16'h0000, 16'h0000, 32'h8000_0000, 1'b1, 1'b1};
    localparam sum_t ZERO_SUM  = '{16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1};
    localparam sum_t ONLY_SEC  = '{16'h0002, 16'h0002, 32'h0000_0009, 1'b1, 1'b1};

    localparam int PLAN_ROWS = 28;
    localparam step_t PLAN [0:PLAN_ROWS-1] = '{
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, END_MARK},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'h7FFF_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'h0000, 16'h0000,
          32'h1, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, WRAP_SUM},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'hFFFF, 16'hFFFF,
          32'hFFFF_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'hFFFF, 16'hFFFF,
          32'h1, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'hFFFF, 16'hFFFF,
          32'hFFFF_FFFF, 8'd1, 1'b1, ZERO_SUM},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
          8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, END_MARK},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0001, 16'h0002,
          32'h5, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0003,
          32'hFFFF_FFF9, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'h0001, 16'h0000,
          32'h8000_0000, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'h0002, 16'h0002,
          32'h9, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, ONLY_SEC},
        '{1'b1, stma_pkg::REG_ROWS_SECOND, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'h5, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0003, 16'h0003,
          32'h3, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, END_MARK},
        '{1'b1, stma_pkg::REG_ROWS_SECOND, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'h0, 8'd1, 1'b0, UNTYPED},
        '{1'b1, stma_pkg::REG_COLS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'hFFFF_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'h0004, 16'h0004,
          32'h4, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b1, END_MARK},
        '{1'b1, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'h0000_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b1, stma_pkg::REG_ROWS_SECOND, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'hABCD_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b1, stma_pkg::REG_COLS_SECOND, stma_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000,
          32'h0000_FFFF, 8'd1, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_FIRST, 16'h0008, 16'h0100,
          32'h7FFF_FFFF, 8'd17, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_LOAD_SECOND, 16'h0009, 16'h0100,
          32'h8000_0000, 8'd17, 1'b0, UNTYPED},
        '{1'b0, stma_pkg::REG_ROWS_FIRST, stma_pkg::OP_MERGE, 16'h0000, 16'h0000, 32'h0,
          8'd1, 1'b0, UNTYPED}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [stma_pkg::OPCODE_W-1:0] opcode;
    logic [stma_pkg::ROW_W-1:0]    row_index;
    logic [stma_pkg::COL_W-1:0]    col_index;
    logic [stma_pkg::VAL_W-1:0]    entry_value;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [stma_pkg::PADDR_W-1:0]  paddr;
    logic [stma_pkg::PDATA_W-1:0]  pwdata;
    logic [stma_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          result_valid;
    logic [stma_pkg::ROW_W-1:0]    out_row;
    logic [stma_pkg::COL_W-1:0]    out_col;
    logic [stma_pkg::VAL_W-1:0]    out_value;
    logic                          entry_present;
    logic                          last_entry;

    stma_pkg::entry_t           first_store [0:LIST_DEPTH-1];
    stma_pkg::entry_t           second_store [0:LIST_DEPTH-1];
    int                         first_fill;
    int                         second_fill;
    logic [stma_pkg::DIM_W-1:0] dim_regs [0:3];

    sum_t sum_queue [$];
    sum_t merge_sums [$];
    sum_t want_sum;

    int errors;
    int commands_sent;
    int merges_sent;
    int beats_checked;
    int stall_cycles;
    int gap_pct;

    sparse_triplet_matrix_add #(
        .LIST_ENTRIES (LIST_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .result_valid  (result_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .entry_present (entry_present),
        .last_entry    (last_entry)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_triplets(input logic [stma_pkg::OPCODE_W-1:0] op,
                                input logic [stma_pkg::ROW_W-1:0] r,
                                input logic [stma_pkg::COL_W-1:0] c,
                                input logic [stma_pkg::VAL_W-1:0] v);
        int               ia;
        int               ib;
        stma_pkg::entry_t e;
        stma_pkg::entry_t x;
        stma_pkg::entry_t y;
        sum_t             held;
        bit               have_held;
        ia = 0;
        ib = 0;
        have_held = 1'b0;
        held = '0;
        merge_sums.delete();
        case (op)
            stma_pkg::OP_LOAD_FIRST:
            begin
                if (first_fill < LIST_DEPTH)
                begin
                    first_store[first_fill] = '{r, c, v};
                    first_fill++;
                end
            end
            stma_pkg::OP_LOAD_SECOND:
            begin
                if (second_fill < LIST_DEPTH)
                begin
                    second_store[second_fill] = '{r, c, v};
                    second_fill++;
                end
            end
            stma_pkg::OP_MERGE:
            begin
                if (dim_regs[stma_pkg::REG_ROWS_FIRST] != dim_regs[stma_pkg::REG_ROWS_SECOND] ||
                    dim_regs[stma_pkg::REG_COLS_FIRST] != dim_regs[stma_pkg::REG_COLS_SECOND] ||
                    (first_fill == 0 && second_fill == 0))
                begin
                    merge_sums.push_back(END_MARK);
                end
                else
                begin
                    while (merge_sums.size() + int'(have_held) < int'(stma_pkg::MAX_RESULTS) &&
                           (ia < first_fill || ib < second_fill))
                    begin
                        if (ia < first_fill && ib < second_fill)
                        begin
                            x = first_store[ia];
                            y = second_store[ib];
                            if ({x.row, x.col} < {y.row, y.col})
                            begin
                                e = x;
                                ia++;
                            end
                            else if ({x.row, x.col} > {y.row, y.col})
                            begin
                                e = y;
                                ib++;
                            end
                            else
                            begin
                                e = '{x.row, x.col, x.value + y.value};
                                ia++;
                                ib++;
                            end
                        end
                        else if (ia < first_fill)
                        begin
                            e = first_store[ia];
                            ia++;
                        end
                        else
                        begin
                            e = second_store[ib];
                            ib++;
                        end
                        if (have_held)
                            merge_sums.push_back(held);
                        held = '{e.row, e.col, e.value, 1'b1, 1'b0};
                        have_held = 1'b1;
                    end
                    held.last = 1'b1;
                    merge_sums.push_back(held);
                end
                first_fill = 0;
                second_fill = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_command(input logic [stma_pkg::OPCODE_W-1:0] op,
                                input logic [stma_pkg::ROW_W-1:0] r,
                                input logic [stma_pkg::COL_W-1:0] c,
                                input logic [stma_pkg::VAL_W-1:0] v,
                                input bit typed, input sum_t typed_sum);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        opcode = op;
        row_index = r;
        col_index = c;
        entry_value = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        add_triplets(op, r, c, v);
        if (typed)
            sum_queue.push_back(typed_sum);
        else
            while (merge_sums.size() > 0)
                sum_queue.push_back(merge_sums.pop_front());
        if (op != OP_UNUSED)
            commands_sent++;
        if (op == stma_pkg::OP_MERGE)
            merges_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [stma_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        dim_regs[idx] = data[stma_pkg::DIM_W-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // shape 0: sorted lists, 1: unsorted lists, 2: first list overfilled
    task automatic run_pair(input int shape);
        stma_pkg::entry_t a_list [0:31];
        stma_pkg::entry_t b_list [0:31];
        int               na;
        int               nb;
        int               la;
        int               lb;
        int               ia;
        int               ib;
        int               pick;
        longint           pos;
        stma_pkg::entry_t t;
        logic [31:0]      v;
        na = ($urandom_range(3) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(5);
        nb = ($urandom_range(3) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(5);
        if (shape == 2)
        begin
            na = LIST_DEPTH + $urandom_range(1, 2);
            nb = $urandom_range(LIST_DEPTH + 2);
        end
        case ($urandom_range(3))
            0: pos = longint'($urandom_range(3));
            1: pos = 64'hFFFF_FFFF - longint'($urandom_range(40));
            default: pos = longint'($urandom);
        endcase
        la = 0;
        lb = 0;
        while ((la < na || lb < nb) && pos <= 64'hFFFF_FFFF)
        begin
            if (la < na && lb < nb)
                pick = $urandom_range(2);
            else if (la < na)
                pick = 0;
            else
                pick = 1;
            v = rand_value();
            if (pick != 1)
            begin
                a_list[la] = {pos[31:0], v};
                la++;
            end
            if (pick != 0)
            begin
                b_list[lb] = {pos[31:0], ($urandom_range(5) == 0) ? -v : rand_value()};
                lb++;
            end
            if ($urandom_range(3) == 0)
                pos = pos + longint'($urandom_range(1, 1 << 20));
            else
                pos = pos + longint'($urandom_range(1, 3));
        end
        if (shape == 1 && la > 1)
        begin
            t = a_list[0];
            a_list[0] = a_list[la-1];
            a_list[la-1] = t;
        end
        if (shape == 1 && lb > 1)
        begin
            t = b_list[lb-1];
            b_list[lb-1] = b_list[0];
            b_list[0] = t;
        end
        ia = 0;
        ib = 0;
        while (ia < la || ib < lb)
        begin
            if (ia < la && (ib >= lb || $urandom_range(1) == 0))
            begin
                send_command(stma_pkg::OP_LOAD_FIRST, a_list[ia].row, a_list[ia].col,
                             a_list[ia].value, 1'b0, UNTYPED);
                ia++;
            end
            else
            begin
                send_command(stma_pkg::OP_LOAD_SECOND, b_list[ib].row, b_list[ib].col,
                             b_list[ib].value, 1'b0, UNTYPED);
                ib++;
            end
        end
        send_command(stma_pkg::OP_MERGE, 16'($urandom), 16'($urandom), $urandom, 1'b0,
                     UNTYPED);
    endtask

    task automatic run_phase(input int budget);
        int base;
        int kind;
        base = commands_sent;
        while (commands_sent - base < budget)
        begin
            kind = $urandom_range(99);
            if (kind < 78)
                run_pair(0);
            else if (kind < 88)
                run_pair(1);
            else if (kind < 94)
                run_pair(2);
            else
                repeat ($urandom_range(1, 4))
                    send_command(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                                 $urandom, 1'b0, UNTYPED);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (sum_queue.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want_sum = sum_queue.pop_front();
                check_field("out_row", 32'(want_sum.row), 32'(out_row));
                check_field("out_col", 32'(want_sum.col), 32'(out_col));
                check_field("out_value", want_sum.value, out_value);
                check_field("entry_present", 32'(want_sum.present), 32'(entry_present));
                check_field("last_entry", 32'(want_sum.last), 32'(last_entry));
                beats_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sparse_triplet_matrix_add verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [stma_pkg::DIM_W-1:0] rows_a;
        logic [stma_pkg::DIM_W-1:0] cols_a;
        logic [stma_pkg::DIM_W-1:0] rows_b;
        logic [stma_pkg::DIM_W-1:0] cols_b;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = stma_pkg::OP_LOAD_FIRST;
        row_index = '0;
        col_index = '0;
        entry_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        commands_sent = 0;
        merges_sent = 0;
        beats_checked = 0;
        stall_cycles = 0;
        gap_pct = 0;
        first_fill = 0;
        second_fill = 0;
        for (int i = 0; i < 4; i++)
            dim_regs[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].is_cfg)
            begin
                settle();
                cfg_write(PLAN[i].cfg_reg, PLAN[i].val);
            end
            else
                for (int k = 0; k < int'(PLAN[i].reps); k++)
                    send_command(PLAN[i].op, PLAN[i].row, PLAN[i].col + 16'(k),
                                 PLAN[i].val, PLAN[i].typed, PLAN[i].want);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            rows_a = 16'($urandom);
            cols_a = 16'($urandom);
            rows_b = rows_a;
            cols_b = cols_a;
            case (ph)
                0:
                begin
                    rows_a = 16'hFFFF;
                    cols_a = 16'hFFFF;
                    rows_b = 16'hFFFF;
                    cols_b = 16'hFFFF;
                end
                2: cols_b = cols_a ^ (16'h1 << $urandom_range(15));
                3:
                begin
                    rows_a = '0;
                    cols_a = '0;
                    rows_b = '0;
                    cols_b = '0;
                end
                4: rows_b = rows_a ^ (16'h1 << $urandom_range(15));
                default: ;
            endcase
            settle();
            cfg_write(stma_pkg::REG_ROWS_FIRST, {16'($urandom), rows_a});
            cfg_write(stma_pkg::REG_COLS_FIRST, {16'($urandom), cols_a});
            cfg_write(stma_pkg::REG_ROWS_SECOND, {16'($urandom), rows_b});
            cfg_write(stma_pkg::REG_COLS_SECOND, {16'($urandom), cols_b});
            case (ph)
                1, 4: gap_pct = 61;
                3: gap_pct = 29;
                default: gap_pct = 0;
            endcase
            run_phase((ph == 2 || ph == 4) ? 25 : 60);
        end

        settle();
        $display("%0d commands driven (%0d merges), %0d result beats checked",
                 commands_sent, merges_sent, beats_checked);
        $display("covered sorted, unsorted and overfilled lists, matched and mismatched sizes");
        if (errors == 0)
            $display("sparse_triplet_matrix_add verification clean");
        else
            $display("sparse_triplet_matrix_add verification failed");
        $finish;
    end

endmodule
